// ===== hdl/radio_voice_effect_chain_top_assert.svh =====
// Assertion macros used by the voice effect chain sequencer
`ifndef RADIO_VOICE_EFFECT_CHAIN_TOP_ASSERT_SVH
`define RADIO_VOICE_EFFECT_CHAIN_TOP_ASSERT_SVH

// same-cycle implication on clk, off while rst_n is low
`define RVFX_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on clk, off while rst_n is low
`define RVFX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rvfx_pkg.sv =====
// Types, constants and microprogram of the voice effect chain
package rvfx_pkg;

    localparam int COEF_FRAC_BITS  = 16;
    localparam int STATE_FRAC_BITS = 8;
    localparam int COEF_W          = 20;
    localparam int STATE_W         = 40;
    localparam int MUL_A_W         = 22;
    localparam int MUL_B_W         = 40;
    localparam int PROD_W          = MUL_A_W + MUL_B_W;
    localparam int WIDE_W          = PROD_W + 1;
    localparam int STEP_W          = 5;
    localparam int GAIN_W          = 9;
    localparam int VOL_SHIFT       = 8;
    localparam int NOISE_SHIFT     = 23 - STATE_FRAC_BITS;

    // register indexes of the configuration port
    localparam logic [2:0] CFG_FILTER_ON = 3'd0;
    localparam logic [2:0] CFG_HISS      = 3'd1;
    localparam logic [2:0] CFG_VOLUME    = 3'd2;
    localparam logic [2:0] CFG_HP_NUM    = 3'd3;
    localparam logic [2:0] CFG_HP_DEN    = 3'd4;
    localparam logic [2:0] CFG_LP_NUM    = 3'd5;
    localparam logic [2:0] CFG_LP_DEN    = 3'd6;

    localparam logic [GAIN_W-1:0]          GAIN_FULL = 9'd256;
    localparam logic signed [MUL_A_W-1:0]  LCG_MUL   = 22'sd1664525;
    localparam logic [31:0]                LCG_INC   = 32'd1013904223;
    localparam logic [31:0]                SEED_INIT = 32'h12345678;

    localparam logic signed [WIDE_W-1:0] WIDE_STATE_MAX =
        {{(WIDE_W-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] WIDE_STATE_MIN =
        {{(WIDE_W-STATE_W+1){1'b1}}, {(STATE_W-1){1'b0}}};
    localparam logic signed [WIDE_W-1:0] COEF_HALF =
        WIDE_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));

    typedef struct packed {
        logic signed [19:0] in_sample;
        logic               sidetone_mode;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] out_sample;
        logic               clipped;
    } out_item_t;

    typedef struct packed {
        logic              filter_on;
        logic [GAIN_W-1:0] hiss_level;
        logic [GAIN_W-1:0] volume;
        logic [59:0]       hp_numerator;
        logic [39:0]       hp_denominator;
        logic [59:0]       lp_numerator;
        logic [39:0]       lp_denominator;
    } cfg_t;

    typedef logic [STEP_W-1:0] step_t;

    // multiplier operand selects
    typedef enum logic [2:0] {
        A_B0, A_B1, A_B2, A_A1, A_A2, A_VOL, A_LCG, A_NOISE
    } a_sel_t;

    typedef enum logic [1:0] {
        B_X, B_Y, B_SEED, B_HISS
    } b_sel_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_Y, OP_ACC, OP_Z1, OP_Z2, OP_SEED, OP_NOISE,
        OP_SIDE_VOL, OP_OUT_VOL, OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        JC_NONE, JC_ALWAYS, JC_SIDE, JC_NO_HISS, JC_NO_FILT
    } jc_t;

    typedef struct packed {
        a_sel_t a_sel;
        b_sel_t b_sel;
        logic   mul_en;
        logic   sec;
        op_t    op;
        jc_t    jc;
        step_t  target;
        logic   last;
    } uop_t;

    typedef struct packed {
        logic load;
        uop_t uop;
    } dp_ctl_t;

    typedef struct packed {
        logic side;
        logic hiss_off;
        logic filter_off;
    } dp_stat_t;

    localparam uop_t UOP_NOP = '0;

    localparam step_t STEP_START = 5'd0;
    localparam step_t STEP_FILT  = 5'd5;
    localparam step_t STEP_POST  = 5'd17;
    localparam step_t STEP_EMIT  = 5'd19;
    localparam step_t STEP_SIDE  = 5'd20;

    function automatic logic signed [STATE_W-1:0] sat_state(
        input logic signed [WIDE_W-1:0] v
    );
        logic signed [STATE_W-1:0] r;
        if (v > WIDE_STATE_MAX)
        begin
            r = WIDE_STATE_MAX[STATE_W-1:0];
        end
        else if (v < WIDE_STATE_MIN)
        begin
            r = WIDE_STATE_MIN[STATE_W-1:0];
        end
        else
        begin
            r = v[STATE_W-1:0];
        end
        return r;
    endfunction

    // round half up to the state grid
    function automatic logic signed [WIDE_W-1:0] round_coef(
        input logic signed [WIDE_W-1:0] p
    );
        return (p + COEF_HALF) >>> COEF_FRAC_BITS;
    endfunction

    function automatic uop_t mk_uop(
        input a_sel_t a,
        input b_sel_t b,
        input logic   m,
        input logic   s,
        input op_t    o,
        input jc_t    j,
        input step_t  t,
        input logic   l
    );
        uop_t w;
        w.a_sel  = a;
        w.b_sel  = b;
        w.mul_en = m;
        w.sec    = s;
        w.op     = o;
        w.jc     = j;
        w.target = t;
        w.last   = l;
        return w;
    endfunction

    // microprogram: incoming hiss, two biquad sections, volume, sidetone prescale
    function automatic uop_t ucode(input step_t s);
        uop_t w;
        case (s)
            5'd0:  w = mk_uop(A_B0,    B_X,    1'b0, 1'b0, OP_NONE,     JC_SIDE,
                              STEP_SIDE, 1'b0);
            5'd1:  w = mk_uop(A_LCG,   B_SEED, 1'b1, 1'b0, OP_NONE,     JC_NO_HISS,
                              STEP_FILT, 1'b0);
            5'd2:  w = mk_uop(A_B0,    B_X,    1'b0, 1'b0, OP_SEED,     JC_NONE,
                              STEP_START, 1'b0);
            5'd3:  w = mk_uop(A_NOISE, B_HISS, 1'b1, 1'b0, OP_NONE,     JC_NONE,
                              STEP_START, 1'b0);
            5'd4:  w = mk_uop(A_B0,    B_X,    1'b0, 1'b0, OP_NOISE,    JC_NONE,
                              STEP_START, 1'b0);
            5'd5:  w = mk_uop(A_B0,    B_X,    1'b1, 1'b0, OP_NONE,     JC_NO_FILT,
                              STEP_POST, 1'b0);
            5'd6:  w = mk_uop(A_B1,    B_X,    1'b1, 1'b0, OP_Y,        JC_NONE,
                              STEP_START, 1'b0);
            5'd7:  w = mk_uop(A_A1,    B_Y,    1'b1, 1'b0, OP_ACC,      JC_NONE,
                              STEP_START, 1'b0);
            5'd8:  w = mk_uop(A_B2,    B_X,    1'b1, 1'b0, OP_Z1,       JC_NONE,
                              STEP_START, 1'b0);
            5'd9:  w = mk_uop(A_A2,    B_Y,    1'b1, 1'b0, OP_ACC,      JC_NONE,
                              STEP_START, 1'b0);
            5'd10: w = mk_uop(A_B0,    B_X,    1'b0, 1'b0, OP_Z2,       JC_NONE,
                              STEP_START, 1'b0);
            5'd11: w = mk_uop(A_B0,    B_X,    1'b1, 1'b1, OP_NONE,     JC_NONE,
                              STEP_START, 1'b0);
            5'd12: w = mk_uop(A_B1,    B_X,    1'b1, 1'b1, OP_Y,        JC_NONE,
                              STEP_START, 1'b0);
            5'd13: w = mk_uop(A_A1,    B_Y,    1'b1, 1'b1, OP_ACC,      JC_NONE,
                              STEP_START, 1'b0);
            5'd14: w = mk_uop(A_B2,    B_X,    1'b1, 1'b1, OP_Z1,       JC_NONE,
                              STEP_START, 1'b0);
            5'd15: w = mk_uop(A_A2,    B_Y,    1'b1, 1'b1, OP_ACC,      JC_NONE,
                              STEP_START, 1'b0);
            5'd16: w = mk_uop(A_B0,    B_X,    1'b0, 1'b1, OP_Z2,       JC_NONE,
                              STEP_START, 1'b0);
            5'd17: w = mk_uop(A_VOL,   B_X,    1'b1, 1'b0, OP_NONE,     JC_SIDE,
                              STEP_EMIT, 1'b0);
            5'd18: w = mk_uop(A_B0,    B_X,    1'b0, 1'b0, OP_OUT_VOL,  JC_NONE,
                              STEP_START, 1'b0);
            5'd19: w = mk_uop(A_B0,    B_X,    1'b0, 1'b0, OP_EMIT,     JC_NONE,
                              STEP_START, 1'b1);
            5'd20: w = mk_uop(A_VOL,   B_X,    1'b1, 1'b0, OP_NONE,     JC_NONE,
                              STEP_START, 1'b0);
            5'd21: w = mk_uop(A_B0,    B_X,    1'b0, 1'b0, OP_SIDE_VOL, JC_ALWAYS,
                              STEP_FILT, 1'b0);
            default: w = mk_uop(A_B0,  B_X,    1'b0, 1'b0, OP_NONE,     JC_NONE,
                                STEP_START, 1'b1);
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/radio_voice_effect_chain_top.sv =====
// A transaction runs the microprogram: hiss (unless off) and volume for incoming samples, a
// prescale for sidetone, and the two filter sections unless bypassed. A new transaction is
// accepted only after the previous one has finished its last step, and the emit step stalls
// while the previous result is still waiting; most steps use the single shared 22 x 40 multiplier.
// Reset (rst_n low, asynchronous): registers to defaults, noise seed to 0x12345678,
// filter delays to zero, no transaction pending.
module radio_voice_effect_chain_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rvfx_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rvfx_pkg::out_item_t  out_data,
    input  logic                 cfg_wr_en,
    input  logic [2:0]           cfg_index,
    input  logic [59:0]          cfg_data
);

    rvfx_pkg::cfg_t      cfg_reg, cfg_next;
    rvfx_pkg::dp_ctl_t   ctl;
    rvfx_pkg::dp_stat_t  stat;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                rvfx_pkg::CFG_FILTER_ON: cfg_next.filter_on      = cfg_data[0];
                rvfx_pkg::CFG_HISS:      cfg_next.hiss_level     = cfg_data[8:0];
                rvfx_pkg::CFG_VOLUME:    cfg_next.volume         = cfg_data[8:0];
                rvfx_pkg::CFG_HP_NUM:    cfg_next.hp_numerator   = cfg_data[59:0];
                rvfx_pkg::CFG_HP_DEN:    cfg_next.hp_denominator = cfg_data[39:0];
                rvfx_pkg::CFG_LP_NUM:    cfg_next.lp_numerator   = cfg_data[59:0];
                rvfx_pkg::CFG_LP_DEN:    cfg_next.lp_denominator = cfg_data[39:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter_on      <= 1'b1;
            cfg_reg.hiss_level     <= 9'd90;
            cfg_reg.volume         <= 9'd256;
            cfg_reg.hp_numerator   <= 60'd65536;
            cfg_reg.hp_denominator <= 40'd0;
            cfg_reg.lp_numerator   <= 60'd65536;
            cfg_reg.lp_denominator <= 40'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rvfx_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    rvfx_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .cfg      (cfg_reg),
        .in_data  (in_data),
        .stat     (stat),
        .out_data (out_data)
    );

endmodule

// ===== hdl/rvfx_dp.sv =====
// Datapath: shared multiplier, sample and biquad delay registers, output register
module rvfx_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rvfx_pkg::dp_ctl_t    ctl,
    input  rvfx_pkg::cfg_t       cfg,
    input  rvfx_pkg::in_item_t   in_data,
    output rvfx_pkg::dp_stat_t   stat,
    output rvfx_pkg::out_item_t  out_data
);

    localparam int SW    = rvfx_pkg::STATE_W;
    localparam int WW    = rvfx_pkg::WIDE_W;
    localparam int EXT_W = rvfx_pkg::STATE_W + 1;
    localparam int CW    = rvfx_pkg::COEF_W;
    localparam int AW    = rvfx_pkg::MUL_A_W;
    localparam int BW    = rvfx_pkg::MUL_B_W;
    localparam int PW    = rvfx_pkg::PROD_W;
    localparam int GW    = rvfx_pkg::GAIN_W;

    localparam logic signed [EXT_W-1:0] TRUNC_BIAS =
        EXT_W'((1 << rvfx_pkg::STATE_FRAC_BITS) - 1);
    localparam logic signed [EXT_W-1:0] TRUNC_NONE = '0;
    localparam logic signed [EXT_W-1:0] OUT_HI = EXT_W'(32767);
    localparam logic signed [EXT_W-1:0] OUT_LO = EXT_W'(-32768);
    localparam logic signed [WW-1:0] SIDE_ROUND = WW'(1 <<< rvfx_pkg::VOL_SHIFT);
    localparam logic signed [WW-1:0] OUT_ROUND  = WW'(1 <<< (rvfx_pkg::VOL_SHIFT - 1));

    rvfx_pkg::uop_t uop;

    logic signed [SW-1:0] x_reg, x_next;
    logic signed [SW-1:0] y_reg, y_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic signed [PW-1:0] acc_reg, acc_next;
    logic                 side_reg, side_next;
    logic [31:0]          seed_reg, seed_next;
    logic signed [SW-1:0] z1_reg [0:1];
    logic signed [SW-1:0] z1_next [0:1];
    logic signed [SW-1:0] z2_reg [0:1];
    logic signed [SW-1:0] z2_next [0:1];
    rvfx_pkg::out_item_t  out_reg, out_next;

    logic [GW-1:0]        vol_eff, hiss_eff;
    logic [16:0]          hiss320;
    logic [59:0]          num_sel;
    logic [39:0]          den_sel;
    logic signed [AW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [WW-1:0] prod_w, diff_w, rnd_prod, rnd_diff;
    logic signed [EXT_W-1:0] trunc_sum, ip;

    assign uop = ctl.uop;

    assign vol_eff  = (cfg.volume > rvfx_pkg::GAIN_FULL) ? rvfx_pkg::GAIN_FULL : cfg.volume;
    assign hiss_eff = (cfg.hiss_level > rvfx_pkg::GAIN_FULL) ?
                      rvfx_pkg::GAIN_FULL : cfg.hiss_level;
    // 320 * hiss as shift and add
    assign hiss320  = {hiss_eff, 8'b0} + {2'b0, hiss_eff, 6'b0};

    assign num_sel = uop.sec ? cfg.lp_numerator : cfg.hp_numerator;
    assign den_sel = uop.sec ? cfg.lp_denominator : cfg.hp_denominator;

    always_comb
    begin
        case (uop.a_sel)
            rvfx_pkg::A_B0:    mul_a = AW'($signed(num_sel[0 +: CW]));
            rvfx_pkg::A_B1:    mul_a = AW'($signed(num_sel[CW +: CW]));
            rvfx_pkg::A_B2:    mul_a = AW'($signed(num_sel[2*CW +: CW]));
            rvfx_pkg::A_A1:    mul_a = AW'($signed(den_sel[0 +: CW]));
            rvfx_pkg::A_A2:    mul_a = AW'($signed(den_sel[CW +: CW]));
            rvfx_pkg::A_VOL:   mul_a = $signed({{(AW-GW){1'b0}}, vol_eff});
            rvfx_pkg::A_LCG:   mul_a = rvfx_pkg::LCG_MUL;
            // upper seed half minus 32768 is the same bits with the top bit flipped
            rvfx_pkg::A_NOISE: mul_a = AW'($signed({~seed_reg[31], seed_reg[30:16]}));
            default:           mul_a = '0;
        endcase
    end

    always_comb
    begin
        case (uop.b_sel)
            rvfx_pkg::B_X:    mul_b = x_reg;
            rvfx_pkg::B_Y:    mul_b = y_reg;
            rvfx_pkg::B_SEED: mul_b = $signed({{(BW-32){1'b0}}, seed_reg});
            rvfx_pkg::B_HISS: mul_b = $signed({{(BW-17){1'b0}}, hiss320});
            default:          mul_b = '0;
        endcase
    end

    assign prod_next = uop.mul_en ? (PW'(mul_a) * PW'(mul_b)) : prod_reg;

    assign prod_w   = WW'(prod_reg);
    assign diff_w   = WW'(acc_reg) - prod_w;
    assign rnd_prod = rvfx_pkg::round_coef(prod_w);
    assign rnd_diff = rvfx_pkg::round_coef(diff_w);

    // truncate toward zero, then clamp to 16 bits
    assign trunc_sum = EXT_W'(x_reg) + (x_reg[SW-1] ? TRUNC_BIAS : TRUNC_NONE);
    assign ip        = trunc_sum >>> rvfx_pkg::STATE_FRAC_BITS;

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        side_next = side_reg;
        seed_next = seed_reg;
        z1_next   = z1_reg;
        z2_next   = z2_reg;
        out_next  = out_reg;

        if (ctl.load)
        begin
            x_next    = SW'(in_data.in_sample) <<< rvfx_pkg::STATE_FRAC_BITS;
            side_next = in_data.sidetone_mode;
        end

        case (uop.op)
            rvfx_pkg::OP_NONE:
            begin
            end
            rvfx_pkg::OP_Y:
            begin
                y_next = rvfx_pkg::sat_state(WW'(z1_reg[uop.sec]) + rnd_prod);
            end
            rvfx_pkg::OP_ACC:
            begin
                acc_next = prod_reg;
            end
            rvfx_pkg::OP_Z1:
            begin
                z1_next[uop.sec] = rvfx_pkg::sat_state(rnd_diff + WW'(z2_reg[uop.sec]));
            end
            rvfx_pkg::OP_Z2:
            begin
                z2_next[uop.sec] = rvfx_pkg::sat_state(rnd_diff);
                x_next           = y_reg;
            end
            rvfx_pkg::OP_SEED:
            begin
                seed_next = prod_reg[31:0] + rvfx_pkg::LCG_INC;
            end
            rvfx_pkg::OP_NOISE:
            begin
                x_next = rvfx_pkg::sat_state(WW'(x_reg) + (prod_w >>> rvfx_pkg::NOISE_SHIFT));
            end
            rvfx_pkg::OP_SIDE_VOL:
            begin
                x_next = rvfx_pkg::sat_state((prod_w + SIDE_ROUND) >>>
                                             (rvfx_pkg::VOL_SHIFT + 1));
            end
            rvfx_pkg::OP_OUT_VOL:
            begin
                x_next = rvfx_pkg::sat_state((prod_w + OUT_ROUND) >>> rvfx_pkg::VOL_SHIFT);
            end
            rvfx_pkg::OP_EMIT:
            begin
                if (ip > OUT_HI)
                begin
                    out_next.out_sample = OUT_HI[15:0];
                    out_next.clipped    = 1'b1;
                end
                else if (ip < OUT_LO)
                begin
                    out_next.out_sample = OUT_LO[15:0];
                    out_next.clipped    = 1'b1;
                end
                else
                begin
                    out_next.out_sample = ip[15:0];
                    out_next.clipped    = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg  <= rvfx_pkg::SEED_INIT;
            z1_reg[0] <= '0;
            z1_reg[1] <= '0;
            z2_reg[0] <= '0;
            z2_reg[1] <= '0;
        end
        else
        begin
            seed_reg <= seed_next;
            z1_reg   <= z1_next;
            z2_reg   <= z2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        side_reg <= side_next;
        out_reg  <= out_next;
    end

    assign stat.side       = side_reg;
    assign stat.hiss_off   = (hiss_eff == '0);
    assign stat.filter_off = !cfg.filter_on;
    assign out_data        = out_reg;

endmodule

// ===== hdl/rvfx_seq.sv =====
// Sequencer: step counter, microprogram fetch, jumps and channel handshakes
`include "radio_voice_effect_chain_top_assert.svh"

module rvfx_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  rvfx_pkg::dp_stat_t  stat,
    output rvfx_pkg::dp_ctl_t   ctl
);

    logic                busy_reg, busy_next;
    rvfx_pkg::step_t     step_reg, step_next;
    logic                out_valid_reg, out_valid_next;
    rvfx_pkg::uop_t      uop;
    logic                stall, run, taken, accept, emit;

    assign uop    = rvfx_pkg::ucode(step_reg);
    assign accept = in_valid && !busy_reg;
    // hold the emit step while the previous result is still waiting
    assign stall  = busy_reg && (uop.op == rvfx_pkg::OP_EMIT) && out_valid_reg && !out_ready;
    assign run    = busy_reg && !stall;
    assign emit   = run && (uop.op == rvfx_pkg::OP_EMIT);

    always_comb
    begin
        case (uop.jc)
            rvfx_pkg::JC_NONE:    taken = 1'b0;
            rvfx_pkg::JC_ALWAYS:  taken = 1'b1;
            rvfx_pkg::JC_SIDE:    taken = stat.side;
            rvfx_pkg::JC_NO_HISS: taken = stat.hiss_off;
            rvfx_pkg::JC_NO_FILT: taken = stat.filter_off;
            default:              taken = 1'b0;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            step_next = rvfx_pkg::STEP_START;
        end
        else if (run)
        begin
            step_next = taken ? uop.target : step_reg + 1'b1;
            if (uop.last)
            begin
                busy_next = 1'b0;
            end
        end
    end

    assign out_valid_next = emit || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= rvfx_pkg::STEP_START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign ctl.load  = accept;
    assign ctl.uop   = run ? uop : rvfx_pkg::UOP_NOP;
    assign in_ready  = !busy_reg;
    assign out_valid = out_valid_reg;

    `RVFX_ASSERT_NEXT(a_accept_starts, in_valid && in_ready,
        busy_reg && step_reg == rvfx_pkg::STEP_START, "accepted transaction did not start")

    `RVFX_ASSERT_IMPLY(a_result_from_emit, $rose(out_valid_reg),
        $past(busy_reg) && $past(step_reg) == rvfx_pkg::STEP_EMIT, "result without emit step")

    `RVFX_ASSERT_NEXT(a_bypass_jumps, busy_reg && step_reg == rvfx_pkg::STEP_FILT &&
        stat.filter_off, step_reg == rvfx_pkg::STEP_POST, "filter bypass missed")

endmodule
